// ----- rtl/sacl_pkg.sv -----
// Shared constants, codes and helpers for the set-associative cache LRU tracker.
// No dependencies.
package sacl_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int DEF_MAX_SETS   = 64;
    localparam int DEF_MAX_WAYS   = 8;
    localparam int DEF_ADDR_WIDTH = 64;

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int TAG_W      = 62;
    localparam int CNT_W      = 32;
    localparam int SET_BITS_W = 3;
    localparam int BLK_BITS_W = 6;
    localparam int WAYS_W     = 4;
    localparam int SET_RAW_W  = 7;   // set index before the wrap to the set count

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [SET_BITS_W-1:0] RST_SET_BITS    = 3'd1;
    localparam logic [BLK_BITS_W-1:0] RST_BLOCK_BITS  = 6'd4;
    localparam logic [WAYS_W-1:0]     RST_WAYS_IN_USE = 4'd1;

    // Access kinds
    localparam logic [FUNC_W-1:0] FUNC_FETCH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd3;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        sat_inc = (x == {CNT_W{1'b1}}) ? x : x + 1'b1;
    endfunction

endpackage

// ----- rtl/sacl_addr_split.sv -----
// Splits a byte address into set index and tag from the block/set bit counts.
// Depends on sacl_pkg.
module sacl_addr_split #(
    parameter int MAX_SETS   = 64,
    parameter int ADDR_WIDTH = 64,
    parameter int SET_W      = 6
) (
    input  logic [ADDR_WIDTH-1:0]          i_addr,
    input  logic [sacl_pkg::SET_BITS_W-1:0] i_set_bits,
    input  logic [sacl_pkg::BLK_BITS_W-1:0] i_block_bits,
    output logic [SET_W-1:0]               o_set,
    output logic [sacl_pkg::TAG_W-1:0]      o_tag
);
    import sacl_pkg::*;

    localparam int RAW_DEPTH = 1 << SET_RAW_W;

    logic [63:0]            addr64;
    logic [63:0]            blk_sh;
    logic [63:0]            tag_sh;
    logic [SET_RAW_W-1:0]   tag_amt;
    logic [SET_RAW_W-1:0]   smask;
    logic [SET_RAW_W-1:0]   set_raw;
    logic [SET_W-1:0]       mod_tab [RAW_DEPTH];

    // wrap of the raw set index onto the set count, worked out at elaboration
    for (genvar g = 0; g < RAW_DEPTH; g++) begin : g_mod
        assign mod_tab[g] = SET_W'(g % MAX_SETS);
    end

    always_comb begin
        addr64  = 64'(i_addr);
        blk_sh  = addr64 >> i_block_bits;
        tag_amt = SET_RAW_W'(i_block_bits) + SET_RAW_W'(i_set_bits);
        tag_sh  = tag_amt[SET_RAW_W-1] ? 64'd0 : (addr64 >> tag_amt[5:0]);
        for (int i = 0; i < SET_RAW_W; i++) begin
            smask[i] = (SET_BITS_W'(i) < i_set_bits);
        end
        set_raw = blk_sh[SET_RAW_W-1:0] & smask;
    end

    assign o_set = mod_tab[set_raw];
    assign o_tag = tag_sh[TAG_W-1:0];

endmodule

// ----- rtl/sacl_row_mem.sv -----
// Set-row memories: tags per way, and valid/rank status per set; registered reads.
// Depends on sacl_pkg.
module sacl_row_mem #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8,
    parameter int SET_W    = 6,
    parameter int WAY_W    = 3,
    parameter int RANK_W   = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [SET_W-1:0]                     i_rd_set,
    input  logic                                 i_wr_en,
    input  logic [SET_W-1:0]                     i_wr_set,
    input  logic                                 i_wr_tag_en,
    input  logic [WAY_W-1:0]                     i_wr_way,
    input  logic [sacl_pkg::TAG_W-1:0]            i_wr_tag,
    input  logic [MAX_WAYS-1:0]                  i_wr_valid,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]      i_wr_rank,
    output logic [MAX_WAYS-1:0]                  o_rd_valid,
    output logic [MAX_WAYS-1:0][RANK_W-1:0]      o_rd_rank,
    output logic [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0] o_rd_tag
);
    import sacl_pkg::*;

    localparam int STAT_W = MAX_WAYS * (RANK_W + 1);

    logic [TAG_W-1:0]  r_tag_mem  [MAX_SETS][MAX_WAYS];
    logic [STAT_W-1:0] r_stat_mem [MAX_SETS];
    logic [STAT_W-1:0] r_rd_stat;
    logic [MAX_WAYS-1:0][TAG_W-1:0] r_rd_tag;
    logic [MAX_SETS-1:0] r_row_wr;   // row written since reset
    logic                r_row_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_stat_mem[i_wr_set] <= {i_wr_valid, i_wr_rank};
            if (i_wr_tag_en) begin
                r_tag_mem[i_wr_set][i_wr_way] <= i_wr_tag;
            end
        end
        if (i_rd_en) begin
            r_rd_stat <= r_stat_mem[i_rd_set];
            for (int w = 0; w < MAX_WAYS; w++) begin
                r_rd_tag[w] <= r_tag_mem[i_rd_set][w];
            end
        end
    end

    // unwritten rows read as all invalid, rank zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_wr <= '0;
            r_row_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_wr[i_wr_set] <= 1'b1;
            end
            if (i_rd_en) begin
                r_row_ok <= r_row_wr[i_rd_set];
            end
        end
    end

    assign o_rd_valid = r_row_ok ? r_rd_stat[STAT_W-1 -: MAX_WAYS] : '0;
    assign o_rd_rank  = r_row_ok ? r_rd_stat[MAX_WAYS*RANK_W-1:0] : '0;
    assign o_rd_tag   = r_rd_tag;

endmodule

// ----- rtl/sacl_way_upd.sv -----
// Tag compare, victim choice and LRU rank update across the ways of one set.
// Depends on sacl_pkg.
module sacl_way_upd #(
    parameter int MAX_WAYS = 8,
    parameter int WAY_W    = 3,
    parameter int RANK_W   = 3
) (
    input  logic [MAX_WAYS-1:0]                      i_valid,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]          i_rank,
    input  logic [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0] i_line_tag,
    input  logic [sacl_pkg::TAG_W-1:0]                i_tag,
    input  logic [sacl_pkg::WAYS_W-1:0]               i_ways_in_use,
    output logic                                     o_hit,
    output logic                                     o_evict,
    output logic [WAY_W-1:0]                         o_way,
    output logic [MAX_WAYS-1:0]                      o_valid,
    output logic [MAX_WAYS-1:0][RANK_W-1:0]          o_rank
);
    import sacl_pkg::*;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    logic [WAYS_W:0]     n_eff;
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] free_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    lru_way;
    logic [RANK_W-1:0]   lru_rank;
    logic                any_free;
    logic                age_all;
    logic [RANK_W-1:0]   old_rank;

    always_comb begin
        n_eff = (i_ways_in_use == '0) ? (WAYS_W+1)'(1) : {1'b0, i_ways_in_use};
        for (int j = 0; j < MAX_WAYS; j++) begin
            in_use[j]   = ((WAYS_W+1)'(j) < n_eff);
            hit_vec[j]  = in_use[j] & i_valid[j] & (i_line_tag[j] == i_tag);
            free_vec[j] = in_use[j] & ~i_valid[j];
        end

        // lowest index wins
        hit_way  = '0;
        free_way = '0;
        for (int j = MAX_WAYS - 1; j >= 0; j--) begin
            if (hit_vec[j])  hit_way  = WAY_W'(j);
            if (free_vec[j]) free_way = WAY_W'(j);
        end

        // oldest way, lowest index on a tie
        lru_way  = '0;
        lru_rank = '0;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j] && i_rank[j] > lru_rank) begin
                lru_rank = i_rank[j];
                lru_way  = WAY_W'(j);
            end
        end

        o_hit    = |hit_vec;
        any_free = |free_vec;
        o_evict  = !o_hit && !any_free;
        o_way    = o_hit ? hit_way : (any_free ? free_way : lru_way);
        age_all  = !o_hit && any_free;   // fill: every other valid way in use ages, short of the top rank
        old_rank = i_rank[o_way];

        o_valid = i_valid;
        o_valid[o_way] = 1'b1;
        for (int j = 0; j < MAX_WAYS; j++) begin
            o_rank[j] = i_rank[j];
            if (in_use[j] && i_valid[j] && (WAY_W'(j) != o_way) &&
                (age_all || i_rank[j] < old_rank) && (i_rank[j] != RANK_MAX)) begin
                o_rank[j] = i_rank[j] + 1'b1;
            end
        end
        o_rank[o_way] = '0;
    end

endmodule

// ----- rtl/set_assoc_cache_lru_tracker.sv -----
// Top level of the set-associative cache LRU tracker: control, counters, result register.
// Depends on sacl_pkg, sacl_addr_split, sacl_row_mem and sacl_way_upd.
//
// Each transfer on the input channel carries an access kind and a byte address. The
// address is split into a set index and a tag from the set_bits and block_bits
// registers; the set row (tags, valid bits and LRU ranks of all ways) is read from
// on-chip memory, compared, updated and written back. Loads and stores give one
// result, a modify gives two (the second always hits, last set only on it), and an
// instruction fetch gives none and changes nothing. Every result carries the running
// hit, miss and eviction totals, which saturate at all ones. A fetch ends in S_IDLE;
// a load or store reads the set row on accept from the single set-row read port, then
// compares and writes back in S_LOOK; a modify adds S_SECOND, and both wait while the
// result register is full. The result register lets the next item be accepted while a result waits
// for the consumer. Memory rows carry a written-since-reset flag, so no clearing pass
// is needed after reset. Configuration writes are meant for idle periods only.
module set_assoc_cache_lru_tracker #(
    parameter int MAX_SETS   = sacl_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // access input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sacl_pkg::FUNC_W-1:0]     i_func,
    input  logic [ADDR_WIDTH-1:0]           i_access_address,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic                            o_evicted,
    output logic                            o_last,
    output logic [sacl_pkg::CNT_W-1:0]      o_hit_total,
    output logic [sacl_pkg::CNT_W-1:0]      o_miss_total,
    output logic [sacl_pkg::CNT_W-1:0]      o_eviction_total
);
    import sacl_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SECOND
    } t_state;

    t_state r_state;

    // configuration registers
    logic [SET_BITS_W-1:0] r_set_bits;
    logic [BLK_BITS_W-1:0] r_block_bits;
    logic [WAYS_W-1:0]     r_ways_in_use;

    // lookup in flight
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_modify;

    // result register and totals
    logic             r_out_valid;
    logic             r_hit;
    logic             r_evicted;
    logic             r_last;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] r_evictions;

    logic             in_xfer;
    logic             lookup_start;
    logic             out_free;
    logic             look_go;
    logic             res_load;
    logic [SET_W-1:0] split_set;
    logic [TAG_W-1:0] split_tag;

    logic [MAX_WAYS-1:0]             rd_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rd_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag;
    logic                            upd_hit;
    logic                            upd_evict;
    logic [WAY_W-1:0]                upd_way;
    logic [MAX_WAYS-1:0]             upd_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] upd_rank;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= RST_SET_BITS;
            r_block_bits  <= RST_BLOCK_BITS;
            r_ways_in_use <= RST_WAYS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SET_BITS:    r_set_bits    <= i_cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS:  r_block_bits  <= i_cfg_data[BLK_BITS_W-1:0];
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- address split at the input ----
    sacl_addr_split #(
        .MAX_SETS   (MAX_SETS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .SET_W      (SET_W)
    ) u_split (
        .i_addr       (i_access_address),
        .i_set_bits   (r_set_bits),
        .i_block_bits (r_block_bits),
        .o_set        (split_set),
        .o_tag        (split_tag)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_xfer      = i_in_valid && o_in_ready;
    assign lookup_start = in_xfer && (i_func != FUNC_FETCH);

    // result slot is free if empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;
    assign look_go  = (r_state == S_LOOK) && out_free;
    // a new result enters the result register this cycle
    assign res_load = ((r_state == S_LOOK) || (r_state == S_SECOND)) && out_free;

    // ---- set-row storage; read on accept, written back on the lookup cycle ----
    sacl_row_mem #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W),
        .WAY_W    (WAY_W),
        .RANK_W   (RANK_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (lookup_start),
        .i_rd_set    (split_set),
        .i_wr_en     (look_go),
        .i_wr_set    (r_set),
        .i_wr_tag_en (!upd_hit),
        .i_wr_way    (upd_way),
        .i_wr_tag    (r_tag),
        .i_wr_valid  (upd_valid),
        .i_wr_rank   (upd_rank),
        .o_rd_valid  (rd_valid),
        .o_rd_rank   (rd_rank),
        .o_rd_tag    (rd_tag)
    );

    // ---- compare and replacement ----
    sacl_way_upd #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W),
        .RANK_W   (RANK_W)
    ) u_upd (
        .i_valid       (rd_valid),
        .i_rank        (rd_rank),
        .i_line_tag    (rd_tag),
        .i_tag         (r_tag),
        .i_ways_in_use (r_ways_in_use),
        .o_hit         (upd_hit),
        .o_evict       (upd_evict),
        .o_way         (upd_way),
        .o_valid       (upd_valid),
        .o_rank        (upd_rank)
    );

    // ---- sequencer, totals and result register ----
    // The second lookup of a modify finds the line just written at rank zero, so it
    // is a hit that leaves the row untouched; no second memory access is made.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_set       <= '0;
            r_tag       <= '0;
            r_modify    <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_evicted   <= 1'b0;
            r_last      <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evictions <= '0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (lookup_start) begin
                        r_set    <= split_set;
                        r_tag    <= split_tag;
                        r_modify <= (i_func == FUNC_MODIFY);
                        r_state  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (out_free) begin
                        r_hit       <= upd_hit;
                        r_evicted   <= upd_evict;
                        r_last      <= !r_modify;
                        if (upd_hit) begin
                            r_hits <= sat_inc(r_hits);
                        end else begin
                            r_misses <= sat_inc(r_misses);
                        end
                        if (upd_evict) begin
                            r_evictions <= sat_inc(r_evictions);
                        end
                        r_state <= r_modify ? S_SECOND : S_IDLE;
                    end
                end
                S_SECOND: begin
                    if (out_free) begin
                        r_hit       <= 1'b1;
                        r_evicted   <= 1'b0;
                        r_last      <= 1'b1;
                        r_hits      <= sat_inc(r_hits);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // totals only move when a new result is loaded, so they track the held result
    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_hit;
    assign o_evicted        = r_evicted;
    assign o_last           = r_last;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evictions;

endmodule

// ----- tb/set_assoc_cache_lru_tracker_tb.sv -----
// Self-checking testbench for set_assoc_cache_lru_tracker: directed and randomized accesses
// checked against a cycle-free LRU cache predictor kept inside this module.
// Depends on sacl_pkg and the set_assoc_cache_lru_tracker RTL.
module set_assoc_cache_lru_tracker_tb;
    import sacl_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 6;     // extra wait after the last result is taken, as a margin
    localparam int STALL_LIMIT   = 3000;  // cycles with no transfer before giving up
    localparam int LINE_COUNT    = DEF_MAX_SETS * DEF_MAX_WAYS;

    // One result of one lookup, as carried on the output channel
    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic             last;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } t_lookup_result;

    // DUT inputs, known from time zero
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = CFG_SET_BITS;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic [FUNC_W-1:0]     i_func           = FUNC_FETCH;
    logic [63:0]           i_access_address = '0;
    logic                  i_out_ready      = 1'b0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_hit;
    logic                  o_evicted;
    logic                  o_last;
    logic [CNT_W-1:0]      o_hit_total;
    logic [CNT_W-1:0]      o_miss_total;
    logic [CNT_W-1:0]      o_eviction_total;

    // Shadow of the cache: tags, valid bits, LRU ranks (0 = most recent), totals
    logic [TAG_W-1:0]      shadow_tag [LINE_COUNT];
    logic                  shadow_vld [LINE_COUNT];
    logic [2:0]            shadow_age [LINE_COUNT];
    logic [CNT_W-1:0]      hit_cnt;
    logic [CNT_W-1:0]      miss_cnt;
    logic [CNT_W-1:0]      evict_cnt;

    // Shadow of the geometry registers
    logic [SET_BITS_W-1:0] cfg_set_bits;
    logic [BLK_BITS_W-1:0] cfg_block_bits;
    logic [WAYS_W-1:0]     cfg_ways;

    t_lookup_result        expected_results [$];
    int                    mismatch_count = 0;
    int                    idle_pct       = 11;  // shared idle rate of sender and receiver
    int                    sink_hold      = 0;   // receiver hold-off, cycles left
    int                    stall_cycles   = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    set_assoc_cache_lru_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_access_address (i_access_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hit            (o_hit),
        .o_evicted        (o_evicted),
        .o_last           (o_last),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_shadow();
        for (int k = 0; k < LINE_COUNT; k++) begin
            shadow_tag[k] = '0;
            shadow_vld[k] = 1'b0;
            shadow_age[k] = '0;
        end
        hit_cnt        = '0;
        miss_cnt       = '0;
        evict_cnt      = '0;
        cfg_set_bits   = RST_SET_BITS;
        cfg_block_bits = RST_BLOCK_BITS;
        cfg_ways       = RST_WAYS_IN_USE;
    endfunction

    // Ways actually in use: 0 acts as 1, anything above the array size is clamped
    function automatic int ways_active();
        if (cfg_ways == 0)
            return 1;
        if (cfg_ways > DEF_MAX_WAYS)
            return DEF_MAX_WAYS;
        return int'(cfg_ways);
    endfunction

    // Way w becomes most recent; valid ways that were more recent than it age by one
    function automatic void promote_way(input int base, input int n, input int w,
                                        input int old_rank);
        for (int j = 0; j < n; j++) begin
            if (j != w && shadow_vld[base+j] && shadow_age[base+j] < old_rank &&
                shadow_age[base+j] < DEF_MAX_WAYS - 1)
                shadow_age[base+j] = shadow_age[base+j] + 3'd1;
        end
        shadow_age[base+w] = '0;
    endfunction

    // One lookup in one set; returns {hit, evicted} and updates the shadow
    function automatic logic [1:0] probe_set(input int set_idx, input logic [TAG_W-1:0] tag);
        int base;
        int n;
        int hit_way;
        int victim;
        int best;
        base    = set_idx * DEF_MAX_WAYS;
        n       = ways_active();
        hit_way = -1;
        victim  = -1;
        best    = 0;
        for (int i = 0; i < n; i++) begin
            if (hit_way < 0 && shadow_vld[base+i] && shadow_tag[base+i] == tag)
                hit_way = i;
        end
        if (hit_way >= 0) begin
            promote_way(base, n, hit_way, int'(shadow_age[base+hit_way]));
            if (hit_cnt != '1)
                hit_cnt = hit_cnt + 1'b1;
            return 2'b10;
        end
        if (miss_cnt != '1)
            miss_cnt = miss_cnt + 1'b1;
        // lowest free way first
        for (int i = 0; i < n; i++) begin
            if (victim < 0 && !shadow_vld[base+i])
                victim = i;
        end
        if (victim >= 0) begin
            promote_way(base, n, victim, DEF_MAX_WAYS);
            shadow_vld[base+victim] = 1'b1;
            shadow_tag[base+victim] = tag;
            return 2'b00;
        end
        // all full: oldest rank goes, lowest index on a tie
        victim = 0;
        for (int i = 0; i < n; i++) begin
            if (shadow_age[base+i] > best) begin
                best   = int'(shadow_age[base+i]);
                victim = i;
            end
        end
        if (evict_cnt != '1)
            evict_cnt = evict_cnt + 1'b1;
        promote_way(base, n, victim, int'(shadow_age[base+victim]));
        shadow_tag[base+victim] = tag;
        return 2'b01;
    endfunction

    // Queue the results one accepted access is due to produce
    function automatic void predict_access(input logic [FUNC_W-1:0] fn,
                                           input logic [63:0] addr);
        logic [63:0]    set_field;
        logic [63:0]    upper;
        int             set_idx;
        int             shift;
        int             n_lookups;
        logic [1:0]     outcome;
        t_lookup_result res;
        if (fn == FUNC_FETCH)
            return;
        set_field = (addr >> cfg_block_bits) & ((64'd1 << cfg_set_bits) - 64'd1);
        set_idx   = int'(set_field % DEF_MAX_SETS);
        shift     = int'(cfg_set_bits) + int'(cfg_block_bits);
        upper     = (shift >= 64) ? 64'd0 : (addr >> shift);
        n_lookups = (fn == FUNC_MODIFY) ? 2 : 1;
        for (int r = 0; r < n_lookups; r++) begin
            outcome            = probe_set(set_idx, upper[TAG_W-1:0]);
            res.hit            = outcome[1];
            res.evicted        = outcome[0];
            res.last           = (r == n_lookups - 1);
            res.hit_total      = hit_cnt;
            res.miss_total     = miss_cnt;
            res.eviction_total = evict_cnt;
            expected_results.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one access, idling at random first; returns at the edge it transfers
    task automatic send_access(input logic [FUNC_W-1:0] fn, input logic [63:0] addr);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= fn;
        i_access_address <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        predict_access(fn, addr);
    endtask

    // Sender stops and waits until every queued result has been taken
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SET_BITS:    cfg_set_bits   = data[SET_BITS_W-1:0];
            CFG_BLOCK_BITS:  cfg_block_bits = data[BLK_BITS_W-1:0];
            CFG_WAYS_IN_USE: cfg_ways       = data[WAYS_W-1:0];
            default: ;
        endcase
    endtask

    // Geometry changes only with the block idle
    task automatic apply_geometry(input logic [SET_BITS_W-1:0] sb,
                                  input logic [BLK_BITS_W-1:0] bb,
                                  input logic [WAYS_W-1:0] ways);
        settle();
        write_reg(CFG_SET_BITS, CFG_DATA_W'(sb));
        write_reg(CFG_BLOCK_BITS, bb);
        write_reg(CFG_WAYS_IN_USE, CFG_DATA_W'(ways));
    endtask

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return FUNC_FETCH;
        if (r <= 3)
            return FUNC_LOAD;
        if (r <= 6)
            return FUNC_STORE;
        return FUNC_MODIFY;
    endfunction

    // Mostly addresses built from a small pool of tags over a few sets so that
    // hits and evictions are frequent; now and then a fully random address
    function automatic logic [63:0] pick_address(input logic [63:0] tag_salt,
                                                 input int set_salt);
        logic [63:0] addr;
        logic [63:0] tag_v;
        int          shift;
        if ($urandom_range(0, 99) < 12)
            return {$urandom(), $urandom()};
        shift = int'(cfg_set_bits) + int'(cfg_block_bits);
        tag_v = tag_salt ^ 64'($urandom_range(0, ways_active() + 2));
        addr  = {$urandom(), $urandom()} & ((64'd1 << cfg_block_bits) - 64'd1);
        addr  = addr | ((64'(set_salt ^ $urandom_range(0, 3)) &
                         ((64'd1 << cfg_set_bits) - 64'd1)) << cfg_block_bits);
        if (shift < 64)
            addr = addr | (tag_v << shift);
        return addr;
    endfunction

    // One randomized phase at a fixed geometry. hold_cycles > 0 makes the
    // receiver stall while the sender keeps offering, so the block backs up.
    // Midway the sender pauses until all results are back.
    task automatic run_phase(input logic [SET_BITS_W-1:0] sb,
                             input logic [BLK_BITS_W-1:0] bb,
                             input logic [WAYS_W-1:0] ways,
                             input int count, input int hold_cycles);
        logic [63:0]       tag_salt;
        int                set_salt;
        int                lookups_sent;
        int                pause_at;
        logic [FUNC_W-1:0] fn;
        apply_geometry(sb, bb, ways);
        tag_salt     = {$urandom(), $urandom()};
        set_salt     = $urandom_range(0, DEF_MAX_SETS - 1);
        pause_at     = $urandom_range(count / 2, count - 1);
        lookups_sent = 0;
        sink_hold    = hold_cycles;
        while (lookups_sent < count) begin
            fn = pick_func();
            send_access(fn, pick_address(tag_salt, set_salt));
            if (fn != FUNC_FETCH) begin
                lookups_sent++;
                if (lookups_sent == pause_at)
                    settle();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry (2 sets, 16-byte blocks, direct mapped): hit in block,
    // modify second lookup, fetch ignored, evictions, all-ones/zero addresses
    task automatic test_default_geometry();
        send_access(FUNC_LOAD,   64'h0);
        send_access(FUNC_LOAD,   64'hF);
        send_access(FUNC_STORE,  64'h10);
        send_access(FUNC_MODIFY, 64'h10);
        send_access(FUNC_FETCH,  64'hFFFF_FFFF_FFFF_FFFF);
        send_access(FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(FUNC_LOAD,   64'h20);
        send_access(FUNC_STORE,  64'h0);
        send_access(FUNC_LOAD,   64'hAAAA_AAAA_AAAA_AAAA);
        send_access(FUNC_STORE,  64'h5555_5555_5555_5555);
        send_access(FUNC_FETCH,  64'h0);
    endtask

    // Single set, 4 ways: LRU victim order, then shrinking and regrowing the
    // way count (lines beyond it keep their contents), way count 0 and above max
    task automatic test_lru_and_way_count();
        apply_geometry(3'd0, 6'd1, 4'd4);
        for (int t = 1; t <= 4; t++)
            send_access(FUNC_LOAD, 64'(t) << 1);
        send_access(FUNC_LOAD,   64'd1 << 1);
        send_access(FUNC_LOAD,   64'd5 << 1);
        send_access(FUNC_MODIFY, 64'd2 << 1);
        apply_geometry(3'd0, 6'd1, 4'd2);
        send_access(FUNC_LOAD,   64'd1 << 1);
        send_access(FUNC_STORE,  64'd7 << 1);
        apply_geometry(3'd0, 6'd1, 4'd4);
        send_access(FUNC_LOAD,   64'd3 << 1);
        apply_geometry(3'd0, 6'd1, 4'd0);
        send_access(FUNC_LOAD,   64'd9 << 1);
        apply_geometry(3'd0, 6'd1, 4'd15);
        send_access(FUNC_LOAD,   64'd1 << 1);
        send_access(FUNC_STORE,  64'd11 << 1);
    endtask

    // Geometry sweep, extremes included: set bits 0 and 7, block bits 0 and 63,
    // shifts past the address width, way counts 0, 1, 8 and above 8
    task automatic test_geometry_sweep();
        run_phase(3'd1, 6'd4,  4'd2,  120, 0);
        run_phase(3'd0, 6'd0,  4'd1,  120, 0);
        run_phase(3'd7, 6'd63, 4'd8,  120, 0);
        run_phase(3'd6, 6'd32, 4'd8,  120, 0);
        run_phase(3'd3, 6'd5,  4'd15, 120, 0);
        run_phase(3'd2, 6'd60, 4'd0,  120, 0);
        run_phase(3'd6, 6'd1,  4'd4,  120, 0);
        run_phase(3'd4, 6'd3,  4'd9,  120, 0);
        run_phase(3'd5, 6'd58, 4'd3,  120, 0);
        run_phase(3'd2, 6'd2,  4'd8,  120, 0);
    endtask

    // Long receiver stall with the sender pushing back to back
    task automatic test_output_backpressure();
        idle_pct = 0;
        run_phase(3'd2, 6'd4, 4'd2, 40, 240);
        idle_pct = 11;
    endtask

    // No idling on either side
    task automatic test_full_rate();
        idle_pct = 0;
        run_phase(3'd3, 6'd6, 4'd8, 300, 0);
        idle_pct = 11;
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            i_out_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    function automatic void check_field(input string field, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Outputs sampled at the rising edge, before the block's own updates land
    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, got hit=%0b ev=%0b last=%0b",
                         $time, o_hit, o_evicted, o_last);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("hit",            CNT_W'(want.hit),     CNT_W'(o_hit));
                check_field("evicted",        CNT_W'(want.evicted), CNT_W'(o_evicted));
                check_field("last",           CNT_W'(want.last),    CNT_W'(o_last));
                check_field("hit_total",      want.hit_total,       o_hit_total);
                check_field("miss_total",     want.miss_total,      o_miss_total);
                check_field("eviction_total", want.eviction_total,  o_eviction_total);
            end
        end
    end

    // Any transfer, register write or reset cycle counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_shadow();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_geometry();
        test_lru_and_way_count();
        test_geometry_sweep();
        test_output_backpressure();
        test_full_rate();
        settle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
